[design/ffrwl_pkg.sv]
// Package for the FIFO-fair reader-writer lock manager.
// Holds sizes, request and event codes, and the waiter entry type.
// No dependencies; every other file imports it.
package ffrwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_BITS     = 8;
    localparam int WAKE_LIMIT  = 15;
    localparam int WAKE_BITS   = $clog2(WAKE_LIMIT + 1);

    localparam logic [RC_BITS-1:0]   RC_MAX     = {RC_BITS{1'b1}};
    localparam logic [FILL_BITS-1:0] FILL_FULL  = FILL_BITS'(QUEUE_DEPTH);
    localparam logic [WAKE_BITS-1:0] WAKE_FINAL = WAKE_BITS'(WAKE_LIMIT - 1);

    typedef enum logic [1:0] {
        OP_RD_LOCK   = 2'd0,
        OP_RD_UNLOCK = 2'd1,
        OP_WR_LOCK   = 2'd2,
        OP_WR_UNLOCK = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        EV_GRANT    = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_WOKEN    = 3'd2,
        EV_RELEASED = 3'd3,
        EV_FULL     = 3'd4,
        EV_ERROR    = 3'd5
    } event_t;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic               wants_write;
    } waiter_t;

endpackage

[design/ffrwl_if.sv]
// Handshake channels of the lock manager: request channel and event channel.
// Depends on ffrwl_pkg for the id width.
interface ffrwl_req_if
    import ffrwl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [ID_BITS-1:0] requester_id;

    modport source (output valid, output opcode, output requester_id, input ready);
    modport sink   (input valid, input opcode, input requester_id, output ready);
endinterface

interface ffrwl_evt_if
    import ffrwl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [ID_BITS-1:0] task_id;
    logic               as_writer;
    logic [RC_BITS-1:0] readers_holding;
    logic               writer_holding;
    logic               last;

    modport source (output valid, output event_kind, output task_id, output as_writer,
                    output readers_holding, output writer_holding, output last,
                    input ready);
    modport sink   (input valid, input event_kind, input task_id, input as_writer,
                    input readers_holding, input writer_holding, input last,
                    output ready);
endinterface

[design/fifo_fair_reader_writer_lock.sv]
// Top level of the FIFO-fair reader-writer lock manager.
// Depends on ffrwl_pkg, ffrwl_if.sv (channels) and ffrwl_cell (queue slots).
//
// Usage:
//   req  : request beats carry opcode (read lock, read unlock, write lock,
//          write unlock) and requester_id.
//   evt  : event beats report grant, queued, waiter woken, released, queue
//          full or unmatched unlock / overflow, with the lock state after the
//          event; last marks the final beat for a request.
//   One request is in flight at a time. A request is taken when the output
//   register is empty or being emptied; its first event appears the cycle
//   after. With evt ready and one event per request, a new request can be
//   taken every cycle.
//   A release that frees the lock walks the waiter chain from its head, one
//   woken waiter per cycle while evt is ready: a writer alone, or up to 15
//   readers in a row.
//   The waiter queue is a chain of cells that shifts toward the head on each
//   wake; new waiters load at the cell indexed by the fill count.
//   Reset clears the lock state, fill count and output valid flag; the queue
//   cells keep whatever they hold and are only read below the fill count.
//   When evt stalls, the event register holds and no new request or wake step
//   proceeds until the beat is taken.
module fifo_fair_reader_writer_lock
    import ffrwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ffrwl_req_if.sink   req,
    ffrwl_evt_if.source evt
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAKE = 2'b10
    } state_t;

    state_t               state_reg,  state_next;
    logic                 writer_reg, writer_next;
    logic [RC_BITS-1:0]   rc_reg,     rc_next;
    logic [FILL_BITS-1:0] fill_reg,   fill_next;
    logic [WAKE_BITS-1:0] wcnt_reg,   wcnt_next;

    logic                 ev_vld_reg, ev_vld_next;
    event_t               ev_kind_reg, ev_kind_next;
    logic [ID_BITS-1:0]   ev_id_reg,   ev_id_next;
    logic                 ev_wr_reg,   ev_wr_next;
    logic                 ev_last_reg, ev_last_next;

    logic    out_free;
    logic    accept;
    logic    enq;
    logic    pop;
    waiter_t enq_data;
    opcode_t op;
    waiter_t cell_q [QUEUE_DEPTH];
    logic    need_wake;

    assign out_free  = !ev_vld_reg || evt.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign op        = opcode_t'(req.opcode);

    // Queue: chain of cells, head at index 0.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        waiter_t right_in;
        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_in = '0;
        end
        else
        begin : g_mid
            assign right_in = cell_q[i+1];
        end

        ffrwl_cell u_cell (
            .clk       (clk),
            .shift     (pop),
            .load      (enq && (fill_reg == FILL_BITS'(i))),
            .load_data (enq_data),
            .right     (right_in),
            .q         (cell_q[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        writer_next  = writer_reg;
        rc_next      = rc_reg;
        fill_next    = fill_reg;
        wcnt_next    = wcnt_reg;
        ev_vld_next  = ev_vld_reg && !evt.ready;
        ev_kind_next = ev_kind_reg;
        ev_id_next   = ev_id_reg;
        ev_wr_next   = ev_wr_reg;
        ev_last_next = ev_last_reg;
        enq          = 1'b0;
        pop          = 1'b0;
        enq_data     = '0;
        need_wake    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ev_vld_next = 1'b1;
                    ev_id_next  = req.requester_id;
                    ev_wr_next  = 1'b0;
                    enq_data.id = req.requester_id;
                    unique case (op)
                        OP_RD_LOCK:
                        begin
                            enq_data.wants_write = 1'b0;
                            if (!writer_reg && fill_reg == '0)
                            begin
                                if (rc_reg == RC_MAX)
                                begin
                                    ev_kind_next = EV_ERROR;
                                end
                                else
                                begin
                                    rc_next      = rc_reg + 1'b1;
                                    ev_kind_next = EV_GRANT;
                                end
                            end
                            else if (fill_reg == FILL_FULL)
                            begin
                                ev_kind_next = EV_FULL;
                            end
                            else
                            begin
                                enq          = 1'b1;
                                fill_next    = fill_reg + 1'b1;
                                ev_kind_next = EV_QUEUED;
                            end
                        end
                        OP_RD_UNLOCK:
                        begin
                            if (writer_reg || rc_reg == '0)
                            begin
                                ev_kind_next = EV_ERROR;
                            end
                            else
                            begin
                                rc_next      = rc_reg - 1'b1;
                                ev_kind_next = EV_RELEASED;
                                need_wake    = (rc_reg == RC_BITS'(1)) && (fill_reg != '0);
                            end
                        end
                        OP_WR_LOCK:
                        begin
                            enq_data.wants_write = 1'b1;
                            if (!writer_reg && rc_reg == '0)
                            begin
                                writer_next  = 1'b1;
                                ev_kind_next = EV_GRANT;
                                ev_wr_next   = 1'b1;
                            end
                            else if (fill_reg == FILL_FULL)
                            begin
                                ev_kind_next = EV_FULL;
                            end
                            else
                            begin
                                enq          = 1'b1;
                                fill_next    = fill_reg + 1'b1;
                                ev_kind_next = EV_QUEUED;
                            end
                        end
                        OP_WR_UNLOCK:
                        begin
                            if (!writer_reg)
                            begin
                                ev_kind_next = EV_ERROR;
                            end
                            else
                            begin
                                writer_next  = 1'b0;
                                ev_kind_next = EV_RELEASED;
                                need_wake    = (fill_reg != '0);
                            end
                        end
                        default:
                        begin
                            ev_kind_next = EV_ERROR;
                        end
                    endcase
                    ev_last_next = !need_wake;
                    if (need_wake)
                    begin
                        state_next = S_WAKE;
                        wcnt_next  = '0;
                    end
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    // Pop the head waiter and report it.
                    pop          = 1'b1;
                    fill_next    = fill_reg - 1'b1;
                    ev_vld_next  = 1'b1;
                    ev_kind_next = EV_WOKEN;
                    ev_id_next   = cell_q[0].id;
                    ev_wr_next   = cell_q[0].wants_write;
                    if (cell_q[0].wants_write)
                    begin
                        writer_next  = 1'b1;
                        ev_last_next = 1'b1;
                    end
                    else
                    begin
                        rc_next      = rc_reg + 1'b1;
                        wcnt_next    = wcnt_reg + 1'b1;
                        // Stop at an empty queue, a writer next, the wake cap
                        // or a full reader count.
                        ev_last_next = (fill_reg == FILL_BITS'(1)) ||
                                       cell_q[1].wants_write ||
                                       (wcnt_reg == WAKE_FINAL) ||
                                       (rc_reg == RC_MAX - 1'b1);
                    end
                    if (ev_last_next)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            writer_reg <= 1'b0;
            rc_reg     <= '0;
            fill_reg   <= '0;
            wcnt_reg   <= '0;
            ev_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            writer_reg <= writer_next;
            rc_reg     <= rc_next;
            fill_reg   <= fill_next;
            wcnt_reg   <= wcnt_next;
            ev_vld_reg <= ev_vld_next;
        end
    end

    // Event payload and the lock snapshot it carries.
    logic [RC_BITS-1:0] ev_rc_reg;
    logic               ev_wh_reg;

    always_ff @(posedge clk)
    begin
        ev_kind_reg <= ev_kind_next;
        ev_id_reg   <= ev_id_next;
        ev_wr_reg   <= ev_wr_next;
        ev_last_reg <= ev_last_next;
        ev_rc_reg   <= rc_next;
        ev_wh_reg   <= writer_next;
    end

    assign evt.valid           = ev_vld_reg;
    assign evt.event_kind      = ev_kind_reg;
    assign evt.task_id         = ev_id_reg;
    assign evt.as_writer       = ev_wr_reg;
    assign evt.readers_holding = ev_rc_reg;
    assign evt.writer_holding  = ev_wh_reg;
    assign evt.last            = ev_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("waiter count beyond queue depth");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(writer_reg && rc_reg != '0))
        else $error("writer and readers hold the lock together");

    a_wake_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAKE) |-> (fill_reg != '0))
        else $error("wake walk with an empty queue");

    a_accept_event: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ev_vld_reg)
        else $error("accepted request produced no event beat");
`endif

endmodule

[design/ffrwl_cell.sv]
// One slot of the waiter queue; slots form a chain that shifts toward the head.
// Depends on ffrwl_pkg for waiter_t.
module ffrwl_cell
    import ffrwl_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  logic    load,
    input  waiter_t load_data,
    input  waiter_t right,
    output waiter_t q
);

    waiter_t slot_reg;
    waiter_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        priority if (shift)
        begin
            slot_next = right;       // advance toward the head
        end
        else if (load)
        begin
            slot_next = load_data;
        end
        else
        begin
            slot_next = slot_reg;    // hold
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign q = slot_reg;

endmodule

[tb/tb_fifo_fair_reader_writer_lock.sv]
// Testbench for the FIFO-fair reader-writer lock manager: directed corner cases,
// random lock traffic, then the reader-count ceiling, each event beat checked
// against an in-bench lock predictor.
// Depends on ffrwl_pkg, the channels in ffrwl_if.sv and the fifo_fair_reader_writer_lock RTL.
module tb_fifo_fair_reader_writer_lock;
    import ffrwl_pkg::*;

    // Request budget for the whole run.
    localparam int TOTAL_ITEMS   = 310;
    // Requests spent on the reader-count ceiling at the end.
    localparam int CEILING_ITEMS = int'(RC_MAX) + 3;
    localparam int SHOWN_FAULTS  = 10;
    // Worst request walks 15 readers; this margin covers any tail.
    localparam int SETTLE_CYCLES = 40;
    // Generous ceiling, in time units, well above the slowest legal run.
    localparam int RUN_LIMIT     = 8_000_000;

    typedef struct {
        opcode_t            op;
        logic [ID_BITS-1:0] id;
    } lock_req_t;

    typedef struct packed {
        event_t             kind;
        logic [ID_BITS-1:0] task_id;
        logic               as_writer;
        logic [RC_BITS-1:0] readers;
        logic               writer;
        logic               last;
    } lock_event_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    logic clk;
    logic rst_n = 1'b0;

    ffrwl_req_if req_ch ();
    ffrwl_evt_if evt_ch ();

    fifo_fair_reader_writer_lock u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .evt   (evt_ch)
    );

    // Predicted lock state: writer flag, reader count and the FIFO of waiters.
    logic               lock_writer  = 1'b0;
    logic [RC_BITS-1:0] lock_readers = '0;
    waiter_t            lock_waiters[$];

    // Event beats still owed by the block, oldest first.
    lock_event_t        events_due[$];
    // Request beats waiting for the driver.
    lock_req_t          pending_reqs[$];

    int       pushed_reqs = 0;
    int       taken_reqs  = 0;
    int       fault_count = 0;
    logic     req_fire    = 1'b0;

    // Sender burst/gap bookkeeping and receiver stall pattern.
    int       burst_left  = 0;
    int       gap_left    = 0;
    int       rx_left     = 0;
    int       rx_phase    = 0;
    rx_mode_t rx_mode     = RX_STEADY;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [ID_BITS-1:0] random_id();
        return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
    endfunction

    function automatic void log_fault(string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
        begin
            $display("%s", msg);
        end
    endfunction

    // Record one owed beat, tagged with the lock state as it stands now.
    function automatic void note_event(event_t kind, logic [ID_BITS-1:0] id, logic wr);
        lock_event_t ev;
        ev.kind      = kind;
        ev.task_id   = id;
        ev.as_writer = wr;
        ev.readers   = lock_readers;
        ev.writer    = lock_writer;
        ev.last      = 1'b0;
        events_due.push_back(ev);
    endfunction

    // Lock just fell free: hand it to the head writer, or to the run of readers
    // at the head, at most WAKE_LIMIT of them; the rest stay queued.
    function automatic void wake_waiters();
        int      wakes = 0;
        waiter_t head;
        if (lock_waiters.size() == 0)
        begin
            return;
        end
        head = lock_waiters[0];
        if (head.wants_write)
        begin
            head = lock_waiters.pop_front();
            lock_writer = 1'b1;
            note_event(EV_WOKEN, head.id, 1'b1);
            return;
        end
        lock_readers = '0;
        while (lock_waiters.size() > 0 && wakes < WAKE_LIMIT && lock_readers != RC_MAX)
        begin
            head = lock_waiters[0];
            if (head.wants_write)
            begin
                break;
            end
            head = lock_waiters.pop_front();
            lock_readers = lock_readers + 1'b1;
            wakes++;
            note_event(EV_WOKEN, head.id, 1'b0);
        end
    endfunction

    // Park a requester at the tail, or flag a full queue and change nothing.
    function automatic void queue_for_lock(logic [ID_BITS-1:0] id, logic wr);
        waiter_t w;
        if (lock_waiters.size() >= QUEUE_DEPTH)
        begin
            note_event(EV_FULL, id, 1'b0);
            return;
        end
        w.id          = id;
        w.wants_write = wr;
        lock_waiters.push_back(w);
        note_event(EV_QUEUED, id, 1'b0);
    endfunction

    // Advance the predicted lock by one request and queue the beats it owes.
    function automatic void predict_request(opcode_t op, logic [ID_BITS-1:0] id);
        lock_event_t final_ev;
        case (op)
            OP_RD_LOCK:
            begin
                // Readers bypass the queue only when nobody waits.
                if (!lock_writer && lock_waiters.size() == 0)
                begin
                    if (lock_readers == RC_MAX)
                    begin
                        note_event(EV_ERROR, id, 1'b0);
                    end
                    else
                    begin
                        lock_readers = lock_readers + 1'b1;
                        note_event(EV_GRANT, id, 1'b0);
                    end
                end
                else
                begin
                    queue_for_lock(id, 1'b0);
                end
            end
            OP_RD_UNLOCK:
            begin
                if (lock_writer || lock_readers == '0)
                begin
                    note_event(EV_ERROR, id, 1'b0);
                end
                else
                begin
                    lock_readers = lock_readers - 1'b1;
                    note_event(EV_RELEASED, id, 1'b0);
                    if (lock_readers == '0)
                    begin
                        wake_waiters();
                    end
                end
            end
            OP_WR_LOCK:
            begin
                // A holder asking again is not caught; it queues like anyone.
                if (!lock_writer && lock_readers == '0)
                begin
                    lock_writer = 1'b1;
                    note_event(EV_GRANT, id, 1'b1);
                end
                else
                begin
                    queue_for_lock(id, 1'b1);
                end
            end
            default:
            begin
                if (!lock_writer)
                begin
                    note_event(EV_ERROR, id, 1'b0);
                end
                else
                begin
                    lock_writer = 1'b0;
                    note_event(EV_RELEASED, id, 1'b0);
                    wake_waiters();
                end
            end
        endcase
        // Every request owes at least one beat; mark its final one.
        final_ev = events_due[events_due.size() - 1];
        final_ev.last = 1'b1;
        events_due[events_due.size() - 1] = final_ev;
    endfunction

    function automatic void send_request(opcode_t op, logic [ID_BITS-1:0] id);
        lock_req_t r;
        r.op = op;
        r.id = id;
        pending_reqs.push_back(r);
        pushed_reqs++;
    endfunction

    // Hold the sender until every request is taken and every beat has come.
    task automatic wait_idle();
        @(negedge clk);
        while (taken_reqs != pushed_reqs || events_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Release whatever the predictor says is held until the lock is free.
    task automatic drain_lock();
        wait_idle();
        while (lock_writer || lock_readers != '0)
        begin
            if (lock_writer)
            begin
                send_request(OP_WR_UNLOCK, random_id());
            end
            else
            begin
                repeat (lock_readers) send_request(OP_RD_UNLOCK, random_id());
            end
            wait_idle();
        end
    endtask

    // Request driver: launch a beat on the falling edge once the previous one
    // was taken, in bursts separated by random gaps.
    always @(negedge clk)
    begin : request_driver
        lock_req_t next_req;
        if (rst_n && (!req_ch.valid || req_fire))
        begin
            if (gap_left > 0 || pending_reqs.size() == 0)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                req_ch.valid <= 1'b0;
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.opcode       <= next_req.op;
                req_ch.requester_id <= next_req.id;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // Mix short bursts with long gap-free stretches.
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Event receiver: switch between always ready, random stalls and a fixed
    // stall rhythm, so stalls can land on any beat of a wake walk.
    always @(negedge clk)
    begin : event_receiver
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(40, 240);
        end
        else
        begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_STEADY:   evt_ch.ready <= 1'b1;
            RX_RANDOM:   evt_ch.ready <= ($urandom_range(0, 2) != 0);
            default:     evt_ch.ready <= ((rx_phase % 7) < 4);
        endcase
    end

    // Monitor: on each rising edge check a taken event beat against the oldest
    // owed beat, then run the predictor for a taken request beat.
    always @(posedge clk)
    begin : lock_monitor
        lock_event_t want;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (events_due.size() == 0)
                begin
                    log_fault($sformatf("unexpected event beat: kind %0d task %0d",
                                        evt_ch.event_kind, evt_ch.task_id));
                end
                else
                begin
                    want = events_due.pop_front();
                    if (evt_ch.event_kind !== want.kind ||
                        evt_ch.task_id !== want.task_id ||
                        evt_ch.as_writer !== want.as_writer ||
                        evt_ch.readers_holding !== want.readers ||
                        evt_ch.writer_holding !== want.writer ||
                        evt_ch.last !== want.last)
                    begin
                        log_fault($sformatf({"event mismatch: expected kind %0d task %0d ",
                                             "wr %0b readers %0d writer %0b last %0b, got ",
                                             "kind %0d task %0d wr %0b readers %0d ",
                                             "writer %0b last %0b"},
                                            want.kind, want.task_id, want.as_writer,
                                            want.readers, want.writer, want.last,
                                            evt_ch.event_kind, evt_ch.task_id,
                                            evt_ch.as_writer, evt_ch.readers_holding,
                                            evt_ch.writer_holding, evt_ch.last));
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken_reqs++;
                predict_request(opcode_t'(req_ch.opcode), req_ch.requester_id);
            end
        end
    end

    initial
    begin : stimulus
        int                 picked;
        int                 n;
        logic [ID_BITS-1:0] owner;

        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_RD_LOCK;
        req_ch.requester_id = '0;
        evt_ch.ready        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Plain grant and release, then unlocks nobody holds.
        send_request(OP_RD_LOCK, 8'h00);
        send_request(OP_RD_UNLOCK, 8'h00);
        send_request(OP_RD_UNLOCK, 8'hFF);
        send_request(OP_WR_UNLOCK, 8'hAA);
        // Writer takes the lock; a read unlock under a writer is unmatched.
        send_request(OP_WR_LOCK, 8'h55);
        send_request(OP_RD_UNLOCK, 8'h12);
        // Fill the queue with readers and the holder itself, overrun it, then
        // release so fifteen readers wake in one walk and stop at the writer.
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            send_request(OP_RD_LOCK, ID_BITS'(8'h80 + i));
        end
        send_request(OP_WR_LOCK, 8'h55);
        send_request(OP_RD_LOCK, 8'hFF);
        send_request(OP_WR_UNLOCK, 8'h55);
        drain_lock();

        // Random traffic: mostly well-formed lock/unlock sequences, some noise,
        // leaving room in the budget for the reader-count ceiling.
        while (pushed_reqs + CEILING_ITEMS < TOTAL_ITEMS)
        begin
            picked = $urandom_range(0, 99);
            if (picked < 20)
            begin
                repeat ($urandom_range(1, 6))
                    send_request(opcode_t'($urandom_range(0, 3)), random_id());
            end
            else if (picked < 55)
            begin
                // Convoy: a writer asks for the lock while readers and writers pile up,
                // sometimes past the queue depth, then the writer lets go.
                if ($urandom_range(0, 3) != 0)
                begin
                    drain_lock();
                end
                owner = random_id();
                send_request(OP_WR_LOCK, owner);
                repeat ($urandom_range(1, 18))
                    send_request(($urandom_range(0, 4) == 0) ? OP_WR_LOCK : OP_RD_LOCK,
                                 random_id());
                send_request(OP_WR_UNLOCK, owner);
            end
            else if (picked < 80)
            begin
                n = $urandom_range(1, 10);
                repeat (n) send_request(OP_RD_LOCK, random_id());
                repeat (n) send_request(OP_RD_UNLOCK, random_id());
            end
            else
            begin
                owner = random_id();
                send_request(OP_WR_LOCK, owner);
                repeat ($urandom_range(0, 3)) send_request(OP_RD_LOCK, random_id());
                send_request(OP_WR_UNLOCK, owner);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain_lock();
            end
        end
        drain_lock();

        // Push the reader count to its ceiling, overflow it, queue behind it.
        repeat (int'(RC_MAX)) send_request(OP_RD_LOCK, random_id());
        send_request(OP_RD_LOCK, random_id());
        send_request(OP_WR_LOCK, random_id());
        send_request(OP_RD_LOCK, random_id());

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (events_due.size() != 0)
        begin
            log_fault($sformatf("%0d event beats never arrived", events_due.size()));
        end
        if (fault_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin : watchdog
        #RUN_LIMIT;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[fifo_fair_reader_writer_lock.f]
design/ffrwl_pkg.sv
design/ffrwl_if.sv
design/ffrwl_cell.sv
design/fifo_fair_reader_writer_lock.sv
tb/tb_fifo_fair_reader_writer_lock.sv
